@@ design/ypcam_pkg.sv @@
package ypcam_pkg;

   // Field widths
   localparam int MODE_W     = 3;
   localparam int YAW_W      = 16;
   localparam int PITCH_W    = 16;
   localparam int SPEED_W    = 17;
   localparam int POS_W      = 32;
   localparam int IN_DATA_W  = 32;
   localparam int OUT_DATA_W = 264;

   // Number formats
   localparam int ANGLE_BITS    = 16;
   localparam int POS_FRAC_BITS = 16;
   localparam int VEC_W         = POS_FRAC_BITS + 2;
   localparam int PROD_W        = 2 * VEC_W + 1 - POS_FRAC_BITS;

   // CORDIC: angle in 2^32 units per turn, x/y with 30 fraction bits
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int CORDIC_TABLE_LEN     = 24;
   localparam int ITER_W               = $clog2(CORDIC_TABLE_LEN);
   localparam int TURN_BITS            = 32;
   localparam int CORDIC_FRAC          = 30;
   localparam int CW                   = 34;
   localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

   localparam logic [SPEED_W-1:0] MOVE_SPEED_RESET = 17'd6554;

   // Saturation limits of a position, at two guard bits
   localparam logic signed [POS_W+1:0] POS_MAX_EXT = {3'b000, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W+1:0] POS_MIN_EXT = {3'b111, {(POS_W-1){1'b0}}};

   // Move modes
   localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FORWARD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BACKWARD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_UP       = 3'd5;
   localparam logic [MODE_W-1:0] MODE_DOWN     = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YAW_RUN,
      ST_YAW_END,
      ST_MOVE_MUL,
      ST_MOVE_X,
      ST_MOVE_Z,
      ST_PITCH_RUN,
      ST_PITCH_END,
      ST_LOOK_MUL,
      ST_LOOK_X,
      ST_LOOK_Z,
      ST_UP_X,
      ST_UP_Z,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_A_SPEED,
      MUL_A_COS_P,
      MUL_A_SIN_P
   } mul_a_type;

   typedef enum logic {
      MUL_B_SIN_Y,
      MUL_B_COS_Y
   } mul_b_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              cap_in;
      logic              cordic_load;
      logic              cordic_pitch;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              store_yaw;
      logic              store_pitch;
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      logic              eye_x_en;
      logic              eye_x_sub;
      logic              eye_y_en;
      logic              eye_y_sub;
      logic              eye_z_en;
      logic              eye_z_sub;
      logic              look_x_en;
      logic              look_z_en;
      logic              up_x_en;
      logic              up_z_en;
      logic              load_out;
   } dp_cmd_type;

   // Result item, last declared field (eye_x) in the low bits
   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_used;
      logic signed [VEC_W-1:0]   up_z;
      logic signed [VEC_W-1:0]   up_y;
      logic signed [VEC_W-1:0]   up_x;
      logic signed [POS_W-1:0]   look_z;
      logic signed [POS_W-1:0]   look_y;
      logic signed [POS_W-1:0]   look_x;
      logic signed [POS_W-1:0]   eye_z;
      logic signed [POS_W-1:0]   eye_y;
      logic signed [POS_W-1:0]   eye_x;
   } rsp_type;

   // atan(2^-i) in 2^32 units per turn
   function automatic logic [TURN_BITS-1:0] atan_turn(input logic [ITER_W-1:0] idx);
      logic [TURN_BITS-1:0] r;
      case (idx)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10680862;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Clamp a widened position sum to the 32-bit signed range
   function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      logic [POS_W-1:0] r;
      if (v > POS_MAX_EXT) begin
         r = POS_MAX_EXT[POS_W-1:0];
      end else if (v < POS_MIN_EXT) begin
         r = POS_MIN_EXT[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/ypcam_ctrl.sv @@
module ypcam_ctrl #(
   parameter int CORDIC_STEPS = ypcam_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ypcam_pkg::MODE_W-1:0] req_mode,
   output ypcam_pkg::dp_cmd_type        cmd,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready
);
   import ypcam_pkg::*;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              horiz, along_sin;

   // Move decode for the captured mode
   always_comb begin
      horiz     = mode_ff inside {MODE_FORWARD, MODE_LEFT, MODE_BACKWARD, MODE_RIGHT};
      along_sin = mode_ff inside {MODE_FORWARD, MODE_BACKWARD};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         mode_ff      <= MODE_UPDATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.mul_a    = MUL_A_SPEED;
      cmd.mul_b    = MUL_B_SIN_Y;
      cmd.iter     = iter_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap_in      = 1'b1;
               cmd.cordic_load = 1'b1;
               mode_in         = req_mode;
               iter_in         = '0;
               state_in        = ST_YAW_RUN;
            end
         end
         ST_YAW_RUN: begin
            cmd.cordic_step = 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = ST_YAW_END;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_YAW_END: begin
            cmd.store_yaw = 1'b1;
            state_in      = ST_MOVE_MUL;
         end
         // speed times the x-axis factor
         ST_MOVE_MUL: begin
            cmd.mul_a = MUL_A_SPEED;
            cmd.mul_b = along_sin ? MUL_B_SIN_Y : MUL_B_COS_Y;
            state_in  = ST_MOVE_X;
         end
         ST_MOVE_X: begin
            cmd.eye_x_en  = horiz;
            cmd.eye_x_sub = mode_ff inside {MODE_FORWARD, MODE_LEFT};
            cmd.mul_a     = MUL_A_SPEED;
            cmd.mul_b     = along_sin ? MUL_B_COS_Y : MUL_B_SIN_Y;
            state_in      = ST_MOVE_Z;
         end
         ST_MOVE_Z: begin
            cmd.eye_z_en     = horiz;
            cmd.eye_z_sub    = mode_ff inside {MODE_FORWARD, MODE_RIGHT};
            cmd.eye_y_en     = mode_ff inside {MODE_UP, MODE_DOWN};
            cmd.eye_y_sub    = (mode_ff == MODE_DOWN);
            cmd.cordic_load  = 1'b1;
            cmd.cordic_pitch = 1'b1;
            iter_in          = '0;
            state_in         = ST_PITCH_RUN;
         end
         ST_PITCH_RUN: begin
            cmd.cordic_step = 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = ST_PITCH_END;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_PITCH_END: begin
            cmd.store_pitch = 1'b1;
            state_in        = ST_LOOK_MUL;
         end
         ST_LOOK_MUL: begin
            cmd.mul_a = MUL_A_COS_P;
            cmd.mul_b = MUL_B_SIN_Y;
            state_in  = ST_LOOK_X;
         end
         ST_LOOK_X: begin
            cmd.look_x_en = 1'b1;
            cmd.mul_a     = MUL_A_COS_P;
            cmd.mul_b     = MUL_B_COS_Y;
            state_in      = ST_LOOK_Z;
         end
         ST_LOOK_Z: begin
            cmd.look_z_en = 1'b1;
            cmd.mul_a     = MUL_A_SIN_P;
            cmd.mul_b     = MUL_B_SIN_Y;
            state_in      = ST_UP_X;
         end
         ST_UP_X: begin
            cmd.up_x_en = 1'b1;
            cmd.mul_a   = MUL_A_SIN_P;
            cmd.mul_b   = MUL_B_COS_Y;
            state_in    = ST_UP_Z;
         end
         ST_UP_Z: begin
            cmd.up_z_en = 1'b1;
            state_in    = ST_FINISH;
         end
         // hand the result to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ design/ypcam_dp.sv @@
module ypcam_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ypcam_pkg::dp_cmd_type                cmd,
   input  logic                                 csr_we,
   input  logic [ypcam_pkg::SPEED_W-1:0]        csr_wdata,
   input  logic [ypcam_pkg::YAW_W-1:0]          in_yaw,
   input  logic signed [ypcam_pkg::PITCH_W-1:0] in_pitch,
   output ypcam_pkg::rsp_type                   rsp
);
   import ypcam_pkg::*;

   localparam int CORDIC_SH = CORDIC_FRAC - POS_FRAC_BITS;
   localparam logic signed [CW-1:0] CORDIC_HALF = CW'(2**(CORDIC_SH - 1));
   localparam logic signed [CW-1:0] VEC_ONE     = CW'(2**POS_FRAC_BITS);
   localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(2**(ANGLE_BITS - 2));
   localparam logic signed [2*VEC_W:0] MUL_HALF = (2*VEC_W+1)'(2**(POS_FRAC_BITS - 1));

   // Round a CORDIC coordinate, negated when neg is set, to the vector format and clamp to +-1.0
   function automatic logic [VEC_W-1:0] cordic_round(input logic signed [CW-1:0] v,
                                                      input logic neg);
      logic signed [CW-1:0] f;
      logic signed [CW-1:0] r;
      f = neg ? -v : v;
      r = (f + CORDIC_HALF) >>> CORDIC_SH;
      if (r > VEC_ONE) begin
         r = VEC_ONE;
      end else if (r < -VEC_ONE) begin
         r = -VEC_ONE;
      end
      return r[VEC_W-1:0];
   endfunction

   logic [SPEED_W-1:0]           move_speed_ff;
   logic signed [ANGLE_BITS-1:0] pitch_ff, pitch_in;
   logic signed [CW-1:0]         x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic                         flip_ff, flip_in;
   logic signed [VEC_W-1:0]      sin_y_ff, cos_y_ff, sin_p_ff, cos_p_ff;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic signed [POS_W-1:0]      eye_x_ff, eye_y_ff, eye_z_ff;
   logic signed [POS_W-1:0]      eye_x_in, eye_y_in, eye_z_in;
   logic signed [POS_W-1:0]      look_x_ff, look_z_ff;
   logic signed [VEC_W-1:0]      up_x_ff, up_z_ff;
   rsp_type                      rsp_ff;

   logic signed [ANGLE_BITS-1:0] pitch_raw, angle;
   logic [TURN_BITS-1:0]         a32, a_fold;
   logic signed [CW-1:0]         xs, ys, atan_ext;
   logic signed [VEC_W-1:0]      mul_a_op, mul_b_op;
   logic signed [2*VEC_W-1:0]    mul_full;
   logic signed [2*VEC_W:0]      mul_rnd;
   logic signed [POS_W+1:0]      prod_ext, speed_ext, sin_p_ext;
   logic signed [POS_W+1:0]      ex_ext, ey_ext, ez_ext;

   // Step length register
   always_ff @(posedge clock) begin
      if (reset) begin
         move_speed_ff <= MOVE_SPEED_RESET;
      end else if (csr_we) begin
         move_speed_ff <= csr_wdata;
      end
   end

   // Pitch clamp at capture
   always_comb begin
      pitch_raw = in_pitch[ANGLE_BITS-1:0];
      pitch_in  = pitch_ff;
      if (cmd.cap_in) begin
         if (pitch_raw > QUARTER) begin
            pitch_in = QUARTER;
         end else if (pitch_raw < -QUARTER) begin
            pitch_in = -QUARTER;
         end else begin
            pitch_in = pitch_raw;
         end
      end
   end

   // CORDIC: quadrant fold at load, one micro-rotation per step
   always_comb begin
      angle    = cmd.cordic_pitch ? pitch_ff : in_yaw[ANGLE_BITS-1:0];
      a32      = {angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};
      flip_in  = flip_ff;
      a_fold   = a32;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      xs       = x_ff >>> cmd.iter;
      ys       = y_ff >>> cmd.iter;
      atan_ext = $signed({{(CW-TURN_BITS){1'b0}}, atan_turn(cmd.iter)});
      if (cmd.cordic_load) begin
         flip_in              = a32[TURN_BITS-1] ^ a32[TURN_BITS-2];
         a_fold[TURN_BITS-1]  = a32[TURN_BITS-1] ^ flip_in;
         x_in                 = CORDIC_INV_GAIN;
         y_in                 = '0;
         z_in                 = $signed({{(CW-TURN_BITS){a_fold[TURN_BITS-1]}}, a_fold});
      end else if (cmd.cordic_step) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_ext;
         end
      end
   end

   // Shared multiplier with rounding, registered every cycle
   always_comb begin
      case (cmd.mul_a)
         MUL_A_SPEED: mul_a_op = $signed({1'b0, move_speed_ff});
         MUL_A_COS_P: mul_a_op = cos_p_ff;
         MUL_A_SIN_P: mul_a_op = sin_p_ff;
         default:     mul_a_op = '0;
      endcase
      case (cmd.mul_b)
         MUL_B_SIN_Y: mul_b_op = sin_y_ff;
         MUL_B_COS_Y: mul_b_op = cos_y_ff;
         default:     mul_b_op = '0;
      endcase
      mul_full = mul_a_op * mul_b_op;
      mul_rnd  = $signed({mul_full[2*VEC_W-1], mul_full}) + MUL_HALF;
      prod_in  = mul_rnd[2*VEC_W:POS_FRAC_BITS];
   end

   // Eye position update with saturation
   always_comb begin
      prod_ext  = $signed({{(POS_W+2-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      speed_ext = $signed({{(POS_W+2-SPEED_W){1'b0}}, move_speed_ff});
      sin_p_ext = $signed({{(POS_W+2-VEC_W){sin_p_ff[VEC_W-1]}}, sin_p_ff});
      ex_ext    = $signed({{2{eye_x_ff[POS_W-1]}}, eye_x_ff});
      ey_ext    = $signed({{2{eye_y_ff[POS_W-1]}}, eye_y_ff});
      ez_ext    = $signed({{2{eye_z_ff[POS_W-1]}}, eye_z_ff});
      eye_x_in  = eye_x_ff;
      eye_y_in  = eye_y_ff;
      eye_z_in  = eye_z_ff;
      if (cmd.eye_x_en) begin
         eye_x_in = sat_pos(cmd.eye_x_sub ? ex_ext - prod_ext : ex_ext + prod_ext);
      end
      if (cmd.eye_y_en) begin
         eye_y_in = sat_pos(cmd.eye_y_sub ? ey_ext - speed_ext : ey_ext + speed_ext);
      end
      if (cmd.eye_z_en) begin
         eye_z_in = sat_pos(cmd.eye_z_sub ? ez_ext - prod_ext : ez_ext + prod_ext);
      end
   end

   // Eye state
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff <= '0;
         eye_y_ff <= '0;
         eye_z_ff <= '0;
      end else begin
         eye_x_ff <= eye_x_in;
         eye_y_ff <= eye_y_in;
         eye_z_ff <= eye_z_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      flip_ff  <= flip_in;
      prod_ff  <= prod_in;
      if (cmd.store_yaw) begin
         sin_y_ff <= cordic_round(y_ff, flip_ff);
         cos_y_ff <= cordic_round(x_ff, flip_ff);
      end
      if (cmd.store_pitch) begin
         sin_p_ff <= cordic_round(y_ff, flip_ff);
         cos_p_ff <= cordic_round(x_ff, flip_ff);
      end
      if (cmd.look_x_en) begin
         look_x_ff <= sat_pos(ex_ext - prod_ext);
      end
      if (cmd.look_z_en) begin
         look_z_ff <= sat_pos(ez_ext - prod_ext);
      end
      if (cmd.up_x_en) begin
         up_x_ff <= prod_ff[VEC_W-1:0];
      end
      if (cmd.up_z_en) begin
         up_z_ff <= prod_ff[VEC_W-1:0];
      end
   end

   // Output register, held until the transfer
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.eye_x      <= eye_x_ff;
         rsp_ff.eye_y      <= eye_y_ff;
         rsp_ff.eye_z      <= eye_z_ff;
         rsp_ff.look_x     <= look_x_ff;
         rsp_ff.look_y     <= sat_pos(ey_ext + sin_p_ext);
         rsp_ff.look_z     <= look_z_ff;
         rsp_ff.up_x       <= up_x_ff;
         rsp_ff.up_y       <= cos_p_ff;
         rsp_ff.up_z       <= up_z_ff;
         rsp_ff.pitch_used <= PITCH_W'(pitch_ff);
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ design/yaw_pitch_camera_update_unit.sv @@
// First-person yaw/pitch camera update.
// Input channel req_*: one transfer carries yaw and pitch (binary angles) in
// req_tdata and the move mode in req_tuser. Result channel rsp_*: one transfer
// per input carries eye position, look-at point, up vector and clamped pitch.
// csr_we/csr_wdata write the move step length (unsigned Q1.16); the user is
// to write it only while the unit is idle, the block does not enforce this.
// Each item moves the stored eye along the yaw axes or along y (not in
// update mode), then derives the view from sin/cos of yaw and pitch.
// One iterative CORDIC unit computes yaw then pitch, and one shared
// multiplier does the moves and the view products. A new item is accepted
// only once the previous result has gone to the output register.
// A finished result waits in the output register; while it waits the next
// item is accepted and processed, and it is held in the final step until
// rsp_tready frees the register.
// Reset clears the eye position to zero, sets the step length to 0.1 and
// drops rsp_tvalid.
module yaw_pitch_camera_update_unit #(
   parameter int CORDIC_STEPS = ypcam_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // yaw [15:0], pitch [31:16]
   input  logic [ypcam_pkg::IN_DATA_W-1:0]  req_tdata,
   // mode [2:0]
   input  logic [ypcam_pkg::MODE_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // eye_x, eye_y, eye_z, look_x, look_y, look_z (32 each), up_x, up_y,
   // up_z (18 each), pitch_used (16), zero fill
   output logic [ypcam_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [ypcam_pkg::SPEED_W-1:0]    csr_wdata
);
   import ypcam_pkg::*;

   localparam int RSP_BITS = $bits(rsp_type);

   dp_cmd_type cmd;
   rsp_type    rsp;

   ypcam_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   ypcam_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_yaw    (req_tdata[YAW_W-1:0]),
      .in_pitch  ($signed(req_tdata[YAW_W+PITCH_W-1:YAW_W])),
      .rsp       (rsp)
   );

   // Pack the result, eye_x in the low bits
   assign rsp_tdata = {{(OUT_DATA_W-RSP_BITS){1'b0}}, rsp};

endmodule
